// ===== hdl/b2da_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds the controller/datapath command and status types and the fixed constants.
// No dependencies.
package b2da_pkg;

	// Input and output field widths
	localparam int BIN_W = 32;
	localparam int CHAR_W = 6;
	localparam int DIGITS = 8;
	localparam int BCD_W = DIGITS * 4;

	// Largest value that fits in eight decimal digits; it needs 27 bits
	localparam logic [BIN_W-1:0] MAX_DECIMAL = 32'd99999999;
	localparam int SHIFT_COUNT = 27;
	localparam int CNT_W = $clog2(SHIFT_COUNT);

	// High bits of an ASCII digit code ('0' is 6'b110000)
	localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

	// Controller states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last_shift;
	} dp_stat_t;

endpackage

// ===== hdl/b2da_ctrl.sv =====
// Controller state machine of the converter.
// Depends on b2da_pkg; drives the datapath commands and the port handshake.
module b2da_ctrl import b2da_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);

	state_t state_q;
	state_t state_next;

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_next = ST_CONV;
			end
			ST_CONV: begin
				if (stat.last_shift) state_next = ST_DONE;
			end
			ST_DONE: begin
				state_next = start ? ST_CONV : ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Decode commands and handshake outputs
	always_comb begin
		busy = (state_q == ST_CONV);
		done = (state_q == ST_DONE);
		cmd.load = start && !busy;
		cmd.shift = busy;
	end

endmodule

// ===== hdl/b2da_dp.sv =====
// Datapath of the converter: clamp, shift-and-add-3 register pair, ASCII output.
// Depends on b2da_pkg; steered by b2da_ctrl.
module b2da_dp import b2da_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	input  logic [BIN_W-1:0]        binary_value,
	output dp_stat_t                stat,
	output logic [DIGITS*CHAR_W-1:0] chars,
	output logic                    overflow_flag
);

	logic [SHIFT_COUNT-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic                   ovf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic                   over;

	assign over = (binary_value > MAX_DECIMAL);

	// Add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Load the clamped value, or advance one bit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= over ? MAX_DECIMAL[SHIFT_COUNT-1:0] : binary_value[SHIFT_COUNT-1:0];
			bcd_q <= '0;
			ovf_q <= over;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[SHIFT_COUNT-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[SHIFT_COUNT-1]};
		end
	end

	// Count shifts of the running transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign stat.last_shift = (cnt_q == CNT_W'(SHIFT_COUNT - 1));

	// Map each BCD digit to its ASCII code, most significant digit at the top
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			chars[i*CHAR_W +: CHAR_W] = {ASCII_DIGIT_HI, bcd_q[i*4 +: 4]};
		end
	end

	assign overflow_flag = ovf_q;

endmodule

// ===== hdl/binary_to_decimal_ascii_core.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_ctrl and b2da_dp.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  input   | start & !busy       | binary_value[31:0]
//  result  | done (one cycle)    | digit_ten_millions .. digit_ones[5:0],
//          |                     | overflow_flag
//
// After acceptance, the shift-and-add-3 register takes one step per bit of the
// 27-bit clamped value (one input bit per cycle), then the controller enters
// the done state, with done high for a single cycle. A new transaction may be
// accepted in that done cycle; none is accepted while busy.
// Reset is asynchronous, active low, and returns the controller to idle.
// The receiver cannot stall; the result holds until the next start is accepted.
module binary_to_decimal_ascii_core import b2da_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [BIN_W-1:0]  binary_value,
	output logic              done,
	output logic [CHAR_W-1:0] digit_ten_millions,
	output logic [CHAR_W-1:0] digit_millions,
	output logic [CHAR_W-1:0] digit_hundred_thousands,
	output logic [CHAR_W-1:0] digit_ten_thousands,
	output logic [CHAR_W-1:0] digit_thousands,
	output logic [CHAR_W-1:0] digit_hundreds,
	output logic [CHAR_W-1:0] digit_tens,
	output logic [CHAR_W-1:0] digit_ones,
	output logic              overflow_flag
);

	dp_cmd_t                  cmd;
	dp_stat_t                 stat;
	logic [DIGITS*CHAR_W-1:0] chars;

	b2da_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	b2da_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.binary_value  (binary_value),
		.stat          (stat),
		.chars         (chars),
		.overflow_flag (overflow_flag)
	);

	// Split the character vector into the digit ports
	assign digit_ten_millions      = chars[7*CHAR_W +: CHAR_W];
	assign digit_millions          = chars[6*CHAR_W +: CHAR_W];
	assign digit_hundred_thousands = chars[5*CHAR_W +: CHAR_W];
	assign digit_ten_thousands     = chars[4*CHAR_W +: CHAR_W];
	assign digit_thousands         = chars[3*CHAR_W +: CHAR_W];
	assign digit_hundreds          = chars[2*CHAR_W +: CHAR_W];
	assign digit_tens              = chars[1*CHAR_W +: CHAR_W];
	assign digit_ones              = chars[0*CHAR_W +: CHAR_W];

endmodule

// ===== hdl/b2da_checker.sv =====
// Port-level checker for binary_to_decimal_ascii_core, with its bind.
// Depends on b2da_pkg.
module b2da_checker import b2da_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [CHAR_W-1:0] digit_ten_millions,
	input logic [CHAR_W-1:0] digit_ones,
	input logic              overflow_flag
);

	// An accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// The done strobe lasts one cycle and never overlaps busy
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("done strobe overlapped busy or lasted too long");

	// A saturated result shows a nine in the ones and ten-millions digits
	a_ovf_nines: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow_flag |-> digit_ones == 6'd57 && digit_ten_millions == 6'd57)
		else $error("overflow result is not saturated");

	// The ones and ten-millions result digits are ASCII decimal digits
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> digit_ones >= 6'd48 && digit_ones <= 6'd57
			&& digit_ten_millions >= 6'd48 && digit_ten_millions <= 6'd57)
		else $error("result digit out of ASCII range");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.start              (start),
	.busy               (busy),
	.done               (done),
	.digit_ten_millions (digit_ten_millions),
	.digit_ones         (digit_ones),
	.overflow_flag      (overflow_flag)
);
